/* design/ifb_pkg.sv */
// Package for the information frame builder: item types, queue entry,
// configuration bundle, sequencer step codes and framing constants.
// No dependencies.
`default_nettype none

package ifb_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h5E;
    localparam logic [7:0] ESC_ESC   = 8'h5D;

    localparam logic [7:0] ADDRESS_RESET   = 8'h03;
    localparam logic [7:0] CTRL_ZERO_RESET = 8'h00;
    localparam logic [7:0] CTRL_ONE_RESET  = 8'h80;

    // Configuration register indexes.
    localparam logic [1:0] REG_ADDRESS   = 2'd0;
    localparam logic [1:0] REG_CTRL_ZERO = 2'd1;
    localparam logic [1:0] REG_CTRL_ONE  = 2'd2;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_number;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       frame_end;
    } out_item_t;

    // Classified item as it waits between the front and the back.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_number;
        logic       first;
        logic       escape;
        logic       last;
    } entry_t;

    typedef struct packed {
        logic [7:0] address_byte;
        logic [7:0] control_frame_zero;
        logic [7:0] control_frame_one;
    } cfg_t;

    typedef enum logic [2:0] {
        STEP_FLAG_OPEN,
        STEP_ADDR,
        STEP_CTRL,
        STEP_BCC1,
        STEP_DATA0,
        STEP_DATA1,
        STEP_BCC2,
        STEP_FLAG_CLOSE
    } step_t;

endpackage

`default_nettype wire

/* design/ifb_front.sv */
// Front of the frame builder: takes input items, tracks frame position and
// marks header and escape needs for the back. Depends on ifb_pkg.
`default_nettype none

module ifb_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ifb_pkg::in_item_t item,
    input  wire logic            q_full,
    output logic                 q_write,
    output ifb_pkg::entry_t      q_entry
);

    logic inside_reg;
    logic inside_next;

    assign q_write = push && !q_full;

    always_comb
    begin
        q_entry.payload_byte = item.payload_byte;
        q_entry.frame_number = item.frame_number;
        q_entry.first        = !inside_reg;
        q_entry.escape       = (item.payload_byte == ifb_pkg::FLAG_BYTE) ||
                               (item.payload_byte == ifb_pkg::ESC_BYTE);
        q_entry.last         = item.last_byte;
    end

    always_comb
    begin
        inside_next = inside_reg;
        if (q_write)
        begin
            inside_next = !item.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
        end
        else
        begin
            inside_reg <= inside_next;
        end
    end

endmodule

`default_nettype wire

/* design/ifb_queue.sv */
// Short queue of classified items between the front and the back of the
// frame builder. Depends on ifb_pkg.
`default_nettype none

module ifb_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire ifb_pkg::entry_t wr_entry,
    output logic                 full,
    output logic                 rd_valid,
    output ifb_pkg::entry_t      rd_entry,
    input  wire logic            rd_en
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ifb_pkg::entry_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* design/ifb_back.sv */
// Back of the frame builder: steps through the header (first item of a frame),
// stuffed payload, and BCC2 and closing flag (last item) of each queued item,
// one byte a cycle into the result register unless it is held unpopped. Depends on ifb_pkg.
`default_nettype none

module ifb_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ifb_pkg::cfg_t   cfg,
    input  wire logic            q_valid,
    input  wire ifb_pkg::entry_t q_entry,
    output logic                 q_read,
    output logic                 empty,
    output ifb_pkg::out_item_t   result,
    input  wire logic            pop
);

    ifb_pkg::step_t step_reg, step_next, cur_step, after_step;
    logic           active_reg, active_next;
    logic [7:0]     chk_reg, chk_next;
    logic           res_valid_reg, res_valid_next;
    ifb_pkg::out_item_t res_reg, res_next;

    logic       emit;
    logic       item_done;
    logic [7:0] ctrl;
    logic [7:0] byte_out;

    assign ctrl = q_entry.frame_number ? cfg.control_frame_one : cfg.control_frame_zero;
    assign emit = q_valid && (!res_valid_reg || pop);

    // A fresh item starts with the header only when it opens a frame.
    always_comb
    begin
        if (active_reg)
        begin
            cur_step = step_reg;
        end
        else if (q_entry.first)
        begin
            cur_step = ifb_pkg::STEP_FLAG_OPEN;
        end
        else
        begin
            cur_step = ifb_pkg::STEP_DATA0;
        end
    end

    // Next step of the sequence.
    always_comb
    begin
        after_step = cur_step;
        item_done  = 1'b0;
        case (cur_step)
            ifb_pkg::STEP_FLAG_OPEN:  after_step = ifb_pkg::STEP_ADDR;
            ifb_pkg::STEP_ADDR:       after_step = ifb_pkg::STEP_CTRL;
            ifb_pkg::STEP_CTRL:       after_step = ifb_pkg::STEP_BCC1;
            ifb_pkg::STEP_BCC1:       after_step = ifb_pkg::STEP_DATA0;
            ifb_pkg::STEP_DATA0:
            begin
                if (q_entry.escape)
                begin
                    after_step = ifb_pkg::STEP_DATA1;
                end
                else if (q_entry.last)
                begin
                    after_step = ifb_pkg::STEP_BCC2;
                end
                else
                begin
                    item_done = 1'b1;
                end
            end
            ifb_pkg::STEP_DATA1:
            begin
                if (q_entry.last)
                begin
                    after_step = ifb_pkg::STEP_BCC2;
                end
                else
                begin
                    item_done = 1'b1;
                end
            end
            ifb_pkg::STEP_BCC2:       after_step = ifb_pkg::STEP_FLAG_CLOSE;
            ifb_pkg::STEP_FLAG_CLOSE: item_done = 1'b1;
            default:                  item_done = 1'b1;
        endcase
    end

    // Byte emitted at the current step.
    always_comb
    begin
        case (cur_step)
            ifb_pkg::STEP_FLAG_OPEN:  byte_out = ifb_pkg::FLAG_BYTE;
            ifb_pkg::STEP_ADDR:       byte_out = cfg.address_byte;
            ifb_pkg::STEP_CTRL:       byte_out = ctrl;
            ifb_pkg::STEP_BCC1:       byte_out = cfg.address_byte ^ ctrl;
            ifb_pkg::STEP_DATA0:
                byte_out = q_entry.escape ? ifb_pkg::ESC_BYTE : q_entry.payload_byte;
            ifb_pkg::STEP_DATA1:
                byte_out = (q_entry.payload_byte == ifb_pkg::FLAG_BYTE) ?
                           ifb_pkg::ESC_FLAG : ifb_pkg::ESC_ESC;
            ifb_pkg::STEP_BCC2:       byte_out = chk_reg;
            ifb_pkg::STEP_FLAG_CLOSE: byte_out = ifb_pkg::FLAG_BYTE;
            default:                  byte_out = ifb_pkg::FLAG_BYTE;
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        active_next    = active_reg;
        chk_next       = chk_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        q_read         = 1'b0;
        if (emit)
        begin
            res_valid_next     = 1'b1;
            res_next.out_byte  = byte_out;
            res_next.run_end   = item_done;
            res_next.frame_end = (cur_step == ifb_pkg::STEP_FLAG_CLOSE);
            step_next          = after_step;
            active_next        = !item_done;
            q_read             = item_done;
            // The check covers only the stuffed payload bytes of one frame.
            if (cur_step == ifb_pkg::STEP_DATA0 || cur_step == ifb_pkg::STEP_DATA1)
            begin
                chk_next = chk_reg ^ byte_out;
            end
            else if (cur_step == ifb_pkg::STEP_BCC1 ||
                     cur_step == ifb_pkg::STEP_FLAG_CLOSE)
            begin
                chk_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ifb_pkg::STEP_FLAG_OPEN;
            active_reg    <= 1'b0;
            chk_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            active_reg    <= active_next;
            chk_reg       <= chk_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign empty  = !res_valid_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

/* design/info_frame_builder_top.sv */
// Top level of the information frame builder: configuration registers,
// front, item queue and back. Depends on ifb_pkg, ifb_front, ifb_queue, ifb_back.
//
// Usage:
//   Input channel: an item (payload byte, frame number, last-byte mark) is
//   taken at a clock edge with push high and full low. Result channel: while
//   empty is low the oldest output byte is on result; pop takes it.
//   Configuration: cfg_index/cfg_data are written when cfg_valid is high;
//   cfg_ready is always high. Index 0 is the address, 1 and 2 the control
//   bytes for frame numbers zero and one; other indexes are ignored. Write
//   only while the block is idle.
//   The first byte caused by an accepted item is written to the queue and
//   then registered into result, if the queue ahead of it is empty.
//   Throughput: the back emits one byte a cycle while result is not held;
//   an item yields 1 to 4 bytes after the first item of a frame, 5 to 8
//   for the first item. The queue of QUEUE_DEPTH items absorbs bursts.
//   Reset clears frame state, check byte and queue, and loads the default
//   address and control bytes. When the receiver stalls, the result holds,
//   the queue fills and full rises; nothing is dropped.
`default_nettype none

module info_frame_builder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire ifb_pkg::in_item_t  item,
    output logic                    empty,
    input  wire logic               pop,
    output ifb_pkg::out_item_t      result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_data
);

    ifb_pkg::cfg_t   cfg_reg, cfg_next;
    ifb_pkg::entry_t wr_entry;
    ifb_pkg::entry_t rd_entry;
    logic            q_write;
    logic            q_read;
    logic            q_valid;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ifb_pkg::REG_ADDRESS:   cfg_next.address_byte       = cfg_data;
                ifb_pkg::REG_CTRL_ZERO: cfg_next.control_frame_zero = cfg_data;
                ifb_pkg::REG_CTRL_ONE:  cfg_next.control_frame_one  = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.address_byte       <= ifb_pkg::ADDRESS_RESET;
            cfg_reg.control_frame_zero <= ifb_pkg::CTRL_ZERO_RESET;
            cfg_reg.control_frame_one  <= ifb_pkg::CTRL_ONE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ifb_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .q_full  (full),
        .q_write (q_write),
        .q_entry (wr_entry)
    );

    ifb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_write),
        .wr_entry (wr_entry),
        .full     (full),
        .rd_valid (q_valid),
        .rd_entry (rd_entry),
        .rd_en    (q_read)
    );

    ifb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_entry (rd_entry),
        .q_read  (q_read),
        .empty   (empty),
        .result  (result),
        .pop     (pop)
    );

    // The closing flag always ends the run of its item.
    a_close_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.frame_end |-> result.run_end)
        else $error("closing flag without run end");

    // The closing flag carries the flag value.
    a_close_is_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.frame_end |-> result.out_byte == ifb_pkg::FLAG_BYTE)
        else $error("closing byte is not a flag");

    // An accepted item is waiting in the queue on the next cycle.
    a_item_queued: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> q_valid)
        else $error("accepted item missing from queue");

endmodule

`default_nettype wire
